[rtl/csp_pkg.sv]
package csp_pkg;

  localparam int COORD_BITS = 16;
  // p - s and e - s
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W = PROD_W + 1;
  // |d|^2 is below 2^(2*COORD_BITS+1)
  localparam int LEN_W = 2 * COORD_BITS + 1;
  // divisor 2*|d|^2, and every partial remainder stays below it
  localparam int DEN_W = LEN_W + 1;
  // 2*|dc|*dot + |d|^2
  localparam int NUM_W = COORD_BITS + LEN_W + 2;
  localparam int MUL_W = COORD_BITS + LEN_W;
  localparam int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CASE_DEGEN    = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2,
    CASE_INTERIOR = 2'd3
  } case_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  // what one divider cell hands to the next
  typedef struct packed {
    logic [DEN_W-1:0]      rem_x;
    logic [DEN_W-1:0]      rem_y;
    logic [DEN_W-1:0]      den;
    logic [COORD_BITS-1:0] low_x;
    logic [COORD_BITS-1:0] low_y;
    logic [COORD_BITS-1:0] quo_x;
    logic [COORD_BITS-1:0] quo_y;
    case_t                 code;
  } cell_data_t;

endpackage

[rtl/csp_front.sv]
module csp_front (
  input  logic                clk,
  input  logic                rst,
  input  csp_pkg::seg_t       seg,
  input  logic                in_valid,
  output logic                in_ready,
  input  csp_pkg::coord_t     query_x,
  input  csp_pkg::coord_t     query_y,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::cell_data_t out_data
);
  import csp_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [COORD_BITS-1:0]    mag_x, mag_y;
  logic signed [PROD_W-1:0] sqx_full, sqy_full;
  logic [NUM_W-1:0]         num_x, num_y;
  logic                     over, degen;
  case_t                    code_next;

  logic v1, v2, v3, v4;
  logic a1, a2, a3, a4, a5;

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic signed [PROD_W-1:0] pr_x, pr_y;
  logic [2*COORD_BITS-1:0]  sq_x, sq_y;
  logic signed [DOT_W-1:0]  dot;
  logic [LEN_W-1:0]         len2, len2_4;
  logic [MUL_W-1:0]         mul_x, mul_y;
  case_t                    code4;

  // the user must change segment ends only while idle; the block does not check
  assign dx = $signed({seg.end_x[COORD_BITS-1], seg.end_x})
            - $signed({seg.start_x[COORD_BITS-1], seg.start_x});
  assign dy = $signed({seg.end_y[COORD_BITS-1], seg.end_y})
            - $signed({seg.start_y[COORD_BITS-1], seg.start_y});
  assign mag_x = dx[DIFF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign mag_y = dy[DIFF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  assign degen = (dx == '0) && (dy == '0);

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  assign over = !dot[DOT_W-1] && (dot[DOT_W-2:0] > (DOT_W-1)'(len2));

  always_comb begin
    if (degen) begin
      code_next = CASE_DEGEN;
    end else if (dot[DOT_W-1]) begin
      code_next = CASE_START;
    end else if (over) begin
      code_next = CASE_END;
    end else begin
      code_next = CASE_INTERIOR;
    end
  end

  // round half up; a negative direction needs the half taken toward the start
  assign num_x = NUM_W'({mul_x, 1'b0}) + NUM_W'(len2_4) - NUM_W'(dx[DIFF_W-1]);
  assign num_y = NUM_W'({mul_y, 1'b0}) + NUM_W'(len2_4) - NUM_W'(dy[DIFF_W-1]);

  assign a5 = !out_valid || out_ready;
  assign a4 = !v4 || a5;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign in_ready = a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a1) v1 <= in_valid;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
      if (a5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (a1 && in_valid) begin
      diff_x <= $signed({query_x[COORD_BITS-1], query_x})
              - $signed({seg.start_x[COORD_BITS-1], seg.start_x});
      diff_y <= $signed({query_y[COORD_BITS-1], query_y})
              - $signed({seg.start_y[COORD_BITS-1], seg.start_y});
    end
    if (a2 && v1) begin
      pr_x <= diff_x * dx;
      pr_y <= diff_y * dy;
      sq_x <= sqx_full[2*COORD_BITS-1:0];
      sq_y <= sqy_full[2*COORD_BITS-1:0];
    end
    if (a3 && v2) begin
      dot  <= DOT_W'(pr_x) + DOT_W'(pr_y);
      len2 <= LEN_W'(sq_x) + LEN_W'(sq_y);
    end
    if (a4 && v3) begin
      code4  <= code_next;
      len2_4 <= len2;
      mul_x  <= mag_x * dot[LEN_W-1:0];
      mul_y  <= mag_y * dot[LEN_W-1:0];
    end
    if (a5 && v4) begin
      out_data.rem_x <= num_x[COORD_BITS+DEN_W-1:COORD_BITS];
      out_data.rem_y <= num_y[COORD_BITS+DEN_W-1:COORD_BITS];
      out_data.low_x <= num_x[COORD_BITS-1:0];
      out_data.low_y <= num_y[COORD_BITS-1:0];
      out_data.den   <= {len2_4, 1'b0};
      out_data.quo_x <= '0;
      out_data.quo_y <= '0;
      out_data.code  <= code4;
    end
  end

endmodule

[rtl/csp_div_cell.sv]
module csp_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csp_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::cell_data_t out_data
);
  import csp_pkg::*;

  logic [DEN_W:0]   trial_x, trial_y, sub_x, sub_y;
  logic             bit_x, bit_y;
  cell_data_t       next_data;

  // bring down the next numerator bit and try one subtract per coordinate
  assign trial_x = {in_data.rem_x, in_data.low_x[COORD_BITS-1]};
  assign trial_y = {in_data.rem_y, in_data.low_y[COORD_BITS-1]};
  assign sub_x   = trial_x - {1'b0, in_data.den};
  assign sub_y   = trial_y - {1'b0, in_data.den};
  assign bit_x   = trial_x >= {1'b0, in_data.den};
  assign bit_y   = trial_y >= {1'b0, in_data.den};

  always_comb begin
    next_data       = in_data;
    next_data.rem_x = bit_x ? sub_x[DEN_W-1:0] : trial_x[DEN_W-1:0];
    next_data.rem_y = bit_y ? sub_y[DEN_W-1:0] : trial_y[DEN_W-1:0];
    next_data.low_x = {in_data.low_x[COORD_BITS-2:0], 1'b0};
    next_data.low_y = {in_data.low_y[COORD_BITS-2:0], 1'b0};
    next_data.quo_x = {in_data.quo_x[COORD_BITS-2:0], bit_x};
    next_data.quo_y = {in_data.quo_y[COORD_BITS-2:0], bit_y};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= next_data;
    end
  end

endmodule

[rtl/closest_point_on_segment_core.sv]
// Closest point on a fixed 2-D segment.
// Configuration: write the segment ends on the cfg channel (index 0 start x,
// 1 start y, 2 end x, 3 end y; cfg_ready is always high). Write only while
// no request is in flight. Reset clears all four to zero.
// Input: one query point per request on s_tvalid/s_tready/s_tdata.
// Output: the nearest point on m_tdata and the case code on m_tuser.
// Pipeline: 5 front stages (differences, products, dot and |d|^2, scaling,
// numerator), one divider cell per coordinate bit (COORD_BITS), and the
// output register: 22 register stages at 16 bits.
// Throughput: one request per cycle unless m_tready stalls the output; the
// cell chain resolves one quotient bit per cell for both coordinates at once.
// When m_tready is low the result holds on the outputs and the stages fill
// up behind it; s_tready drops only once every stage is occupied, and any
// empty stage is refilled even while the output waits.
// Reset empties every stage and drops m_tvalid the cycle after.
module closest_point_on_segment_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // query_x, query_y, zero padding
  input  logic [csp_pkg::DATA_W-1:0]         s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // near_x, near_y, zero padding
  output logic [csp_pkg::DATA_W-1:0]         m_tdata,
  // case_code
  output logic [1:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csp_pkg::COORD_BITS-1:0]     cfg_data
);
  import csp_pkg::*;

  seg_t       seg;
  coord_t     query_x, query_y;
  coord_t     near_x, near_y, res_x, res_y;
  logic       chain_ready;

  logic       cv [0:COORD_BITS];
  logic       cr [0:COORD_BITS];
  cell_data_t cd [0:COORD_BITS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_X: seg.start_x <= cfg_data;
        REG_START_Y: seg.start_y <= cfg_data;
        REG_END_X:   seg.end_x   <= cfg_data;
        REG_END_Y:   seg.end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign query_x = s_tdata[COORD_BITS-1:0];
  assign query_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

  csp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .query_x   (query_x),
    .query_y   (query_y),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
    csp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_data   (cd[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_data  (cd[k+1])
    );
  end

  assign chain_ready = !m_tvalid || m_tready;
  assign cr[COORD_BITS] = chain_ready;

  // step from the start toward the end by the rounded quotient
  always_comb begin
    if (($signed({seg.end_x[COORD_BITS-1], seg.end_x})
         - $signed({seg.start_x[COORD_BITS-1], seg.start_x})) < 0) begin
      res_x = seg.start_x - cd[COORD_BITS].quo_x;
    end else begin
      res_x = seg.start_x + cd[COORD_BITS].quo_x;
    end
    if (($signed({seg.end_y[COORD_BITS-1], seg.end_y})
         - $signed({seg.start_y[COORD_BITS-1], seg.start_y})) < 0) begin
      res_y = seg.start_y - cd[COORD_BITS].quo_y;
    end else begin
      res_y = seg.start_y + cd[COORD_BITS].quo_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (chain_ready) begin
      m_tvalid <= cv[COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready && cv[COORD_BITS]) begin
      m_tuser <= cd[COORD_BITS].code;
      case (cd[COORD_BITS].code)
        CASE_END: begin
          near_x <= seg.end_x;
          near_y <= seg.end_y;
        end
        CASE_INTERIOR: begin
          near_x <= res_x;
          near_y <= res_y;
        end
        default: begin
          near_x <= seg.start_x;
          near_y <= seg.start_y;
        end
      endcase
    end
  end

  assign m_tdata = DATA_W'({near_y, near_x});

endmodule

[rtl/csp_checker.sv]
module csp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [csp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [csp_pkg::COORD_BITS-1:0] cfg_data,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [csp_pkg::DATA_W-1:0]     m_tdata,
  input logic [1:0]                     m_tuser
);
  import csp_pkg::*;

  logic [COORD_BITS-1:0] sh_sx, sh_sy, sh_ex, sh_ey;
  logic [COORD_BITS-1:0] out_x, out_y;

  assign out_x = m_tdata[COORD_BITS-1:0];
  assign out_y = m_tdata[2*COORD_BITS-1:COORD_BITS];

  // track the segment ends as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_sx <= '0;
      sh_sy <= '0;
      sh_ex <= '0;
      sh_ey <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_X: sh_sx <= cfg_data;
        REG_START_Y: sh_sy <= cfg_data;
        REG_END_X:   sh_ex <= cfg_data;
        REG_END_Y:   sh_ey <= cfg_data;
        default: ;
      endcase
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_start_case: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == CASE_DEGEN || m_tuser == CASE_START)
      |-> out_x == sh_sx && out_y == sh_sy)
    else $error("start case does not return the start point");

  a_end_case: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == CASE_END |-> out_x == sh_ex && out_y == sh_ey)
    else $error("end case does not return the end point");

  a_degen_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == CASE_DEGEN) == (sh_sx == sh_ex && sh_sy == sh_ey))
    else $error("degenerate code disagrees with segment ends");

endmodule

bind closest_point_on_segment_core csp_checker u_csp_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

[tb/tb_top.sv]
module tb_top;
  import csp_pkg::*;

  typedef struct packed {
    coord_t nx;
    coord_t ny;
    case_t  code;
  } nearest_t;

  // Keeps a copy of the segment ends and the nearest points still owed by the block
  class nearest_point_board;
    coord_t   seg_sx, seg_sy, seg_ex, seg_ey;
    nearest_t pending_nearest[$];
    int       errors;
    int       checked;
    int       case_seen[4];

    function void set_reg(cfg_reg_t idx, coord_t val);
      case (idx)
        REG_START_X: seg_sx = val;
        REG_START_Y: seg_sy = val;
        REG_END_X:   seg_ex = val;
        REG_END_Y:   seg_ey = val;
        default: ;
      endcase
    endfunction

    // floor(base + step*dot/len2 + 1/2) with 0 <= dot <= len2
    function longint round_along(longint base, longint step, longint dot, longint len2);
      longint num;
      longint q;
      num = 2 * (step < 0 ? -step : step) * dot + len2;
      if (step < 0) num = num - 1;
      q = num / (2 * len2);
      return step < 0 ? base - q : base + q;
    endfunction

    function nearest_t nearest_on_segment(coord_t qx, coord_t qy);
      nearest_t r;
      longint   sx, sy, dx, dy, dot, len2;
      sx = seg_sx;
      sy = seg_sy;
      dx = longint'(seg_ex) - sx;
      dy = longint'(seg_ey) - sy;
      if (dx == 0 && dy == 0) begin
        r.nx = seg_sx;
        r.ny = seg_sy;
        r.code = CASE_DEGEN;
      end else begin
        dot = (longint'(qx) - sx) * dx + (longint'(qy) - sy) * dy;
        len2 = dx * dx + dy * dy;
        if (dot < 0) begin
          r.nx = seg_sx;
          r.ny = seg_sy;
          r.code = CASE_START;
        end else if (dot > len2) begin
          r.nx = seg_ex;
          r.ny = seg_ey;
          r.code = CASE_END;
        end else begin
          r.nx = coord_t'(round_along(sx, dx, dot, len2));
          r.ny = coord_t'(round_along(sy, dy, dot, len2));
          r.code = CASE_INTERIOR;
        end
      end
      return r;
    endfunction

    function void note_query(coord_t qx, coord_t qy);
      pending_nearest.push_back(nearest_on_segment(qx, qy));
    endfunction

    task report(string what);
      errors++;
      $display("error %0d: %s", errors, what);
    endtask

    task check_nearest(logic [DATA_W-1:0] data, logic [1:0] user);
      nearest_t want;
      coord_t   got_x;
      coord_t   got_y;
      got_x = data[COORD_BITS-1:0];
      got_y = data[2*COORD_BITS-1:COORD_BITS];
      if (pending_nearest.size() == 0) begin
        report($sformatf("unexpected result (%0d, %0d) code %0d", got_x, got_y, user));
        return;
      end
      want = pending_nearest.pop_front();
      checked++;
      case_seen[int'(want.code)]++;
      if (got_x !== want.nx)
        report($sformatf("result %0d near_x: got %0d, want %0d", checked, got_x, want.nx));
      if (got_y !== want.ny)
        report($sformatf("result %0d near_y: got %0d, want %0d", checked, got_y, want.ny));
      if (case_t'(user) !== want.code)
        report($sformatf("result %0d case_code: got %0d, want %s", checked, user,
                         want.code.name()));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;

  nearest_point_board board;
  int idle_odds = 0;
  int stall_left = 0;
  int settings = 0;

  closest_point_on_segment_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #1600000;
    $display("closest_point_on_segment_core: mismatch");
    $finish;
  end

  // receiver drops m_tready in random bursts while idle_odds is nonzero
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_nearest(m_tdata, m_tuser);
  end

  function coord_t sat_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  // hold valid until the request is taken; leave it high for the next one
  task send_query(coord_t qx, coord_t qy);
    if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_W'({qy, qx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_query(qx, qy);
    @(negedge clk);
  endtask

  task drain_results();
    s_tvalid <= 1'b0;
    while (board.pending_nearest.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(cfg_reg_t idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task set_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    drain_results();
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task pick_segment(output coord_t sx, output coord_t sy, output coord_t ex, output coord_t ey);
    case ($urandom_range(0, 5))
      1: begin
        // short segment: the end within 8 units of the start on each axis
        sx = coord_t'(int'($urandom_range(0, 64000)) - 32000);
        sy = coord_t'(int'($urandom_range(0, 64000)) - 32000);
        ex = coord_t'(int'(sx) + int'($urandom_range(0, 16)) - 8);
        ey = coord_t'(int'(sy) + int'($urandom_range(0, 16)) - 8);
      end
      2: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = sx;
        ey = sy;
      end
      3: begin
        sx = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
        sy = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
        ex = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
        ey = $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
      end
      4: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = $urandom_range(0, 1) ? sx : coord_t'($urandom);
        ey = (ex == sx) ? coord_t'($urandom) : sy;
      end
      default: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
    endcase
  endtask

  task pick_query(output coord_t qx, output coord_t qy);
    longint dx, dy;
    int     t;
    dx = longint'(board.seg_ex) - board.seg_sx;
    dy = longint'(board.seg_ey) - board.seg_sy;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        qx = coord_t'($urandom);
        qy = coord_t'($urandom);
      end
      8: begin
        qx = sat_coord(longint'(board.seg_sx) + int'($urandom_range(0, 6)) - 3);
        qy = sat_coord(longint'(board.seg_sy) + int'($urandom_range(0, 6)) - 3);
      end
      9: begin
        qx = sat_coord(longint'(board.seg_ex) + int'($urandom_range(0, 6)) - 3);
        qy = sat_coord(longint'(board.seg_ey) + int'($urandom_range(0, 6)) - 3);
      end
      default: begin
        // along the segment, slightly past both ends, with some scatter
        t = int'($urandom_range(0, 1200)) - 100;
        qx = sat_coord(board.seg_sx + dx * t / 1000 + int'($urandom_range(0, 80)) - 40);
        qy = sat_coord(board.seg_sy + dy * t / 1000 + int'($urandom_range(0, 80)) - 40);
      end
    endcase
  endtask

  initial begin
    coord_t sx, sy, ex, ey, qx, qy;
    int     phase;
    int     n;
    board = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    idle_odds = 25;

    // reset leaves a point segment at the origin
    send_query(-32768, -32768);
    send_query(32767, 32767);

    // full diagonal: both ends are interior hits, the two other corners round half up
    set_segment(-32768, -32768, 32767, 32767);
    send_query(-32768, -32768);
    send_query(32767, 32767);
    send_query(-32768, 32767);
    send_query(32767, -32768);

    set_segment(100, -200, -300, 400);
    send_query(32767, -32768);
    send_query(-32768, 32767);
    send_query(0, 0);
    send_query(-301, 401);

    // exact halves, once with a rising and once with a falling direction
    set_segment(0, 0, 1, 1);
    send_query(1, 0);
    set_segment(0, 0, -1, -1);
    send_query(-1, 0);

    set_segment(32767, -32768, -32768, 32767);
    send_query(0, 0);
    send_query(32767, 32767);
    send_query(-32768, -32768);

    set_segment(-32768, 32767, -32768, 32767);
    send_query(5, -5);
    send_query(0, 0);

    set_segment(-1000, 7, 1000, 7);
    send_query(-1001, -32768);
    send_query(123, 32767);
    send_query(1000, 0);

    for (phase = 0; phase < 9; phase++) begin
      pick_segment(sx, sy, ex, ey);
      set_segment(sx, sy, ex, ey);
      idle_odds = (phase == 4 || phase == 8) ? 0 : 25;
      for (n = 0; n < 212; n++) begin
        pick_query(qx, qy);
        send_query(qx, qy);
      end
    end

    drain_results();
    repeat (30) @(negedge clk);
    $display("checked %0d nearest points over %0d segment settings", board.checked, settings);
    $display("cases seen: degenerate %0d, start %0d, end %0d, interior %0d",
             board.case_seen[0], board.case_seen[1], board.case_seen[2], board.case_seen[3]);
    if (board.errors == 0) begin
      $display("closest_point_on_segment_core: match");
    end else begin
      $display("closest_point_on_segment_core: mismatch");
    end
    $finish;
  end
endmodule
